// ===== hdl/ucpl_pkg.sv =====
// ----------------------------------------------------------------------------
// ucpl_pkg
// Types and constants shared by the character property lookup modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ucpl_pkg;

   localparam int CODE_W  = 21;
   localparam int OFF_W   = 22;
   localparam int CAT_W   = 5;
   localparam int IDX_W   = 12;
   localparam int COUNT_W = 13;

   localparam logic [CAT_W-1:0] CAT_LU = 5'd0;
   localparam logic [CAT_W-1:0] CAT_LL = 5'd1;
   localparam logic [CAT_W-1:0] CAT_LT = 5'd2;
   localparam logic [CAT_W-1:0] CAT_LM = 5'd3;
   localparam logic [CAT_W-1:0] CAT_NO = 5'd10;
   localparam logic [CAT_W-1:0] CAT_ZS = 5'd22;
   localparam logic [CAT_W-1:0] CAT_CN = 5'd29;

   localparam logic [CODE_W-1:0] MAX_CODE = 21'd1114111;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd1;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef struct packed {
      logic [CODE_W-1:0] start;
      logic [CODE_W-1:0] length;
      logic [CAT_W-1:0]  category;
      logic [OFF_W-1:0]  upper_off;
      logic [OFF_W-1:0]  lower_off;
      logic [OFF_W-1:0]  title_off;
   } entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic wr;       // store one table entry
      logic load;     // latch code point, open the search range
      logic step;     // one probe: narrow the range
      logic finish;   // range check on the final entry, load result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic search_done;
   } status_type;

   // code point plus signed offset, clamped to 0..MAX_CODE
   function automatic logic [CODE_W-1:0] map_char(input logic [CODE_W-1:0] c,
                                                  input logic [OFF_W-1:0] off);
      logic signed [CODE_W+2:0] sum;
      sum = $signed({3'b000, c}) + $signed({{2{off[OFF_W-1]}}, off});
      if (sum < 0) begin
         map_char = '0;
      end else if (sum > $signed({3'b000, MAX_CODE})) begin
         map_char = MAX_CODE;
      end else begin
         map_char = sum[CODE_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ucpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucpl_ctrl
// Sequencer for table writes and binary-search lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module ucpl_ctrl
   import ucpl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       req_action,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy,
   output logic            rsp_strobe
);

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_action == ACT_LOOKUP) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.search_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.wr   = start && req_action == ACT_WRITE;
            cmd.load = start && req_action == ACT_LOOKUP;
         end
         ST_SEARCH: begin
            busy       = 1'b1;
            cmd.step   = !status.search_done;
            cmd.finish = status.search_done;
         end
         default: busy = 1'b0;
      endcase
      strobe_in = cmd.finish;
   end

   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// ===== hdl/ucpl_dp.sv =====
// ----------------------------------------------------------------------------
// ucpl_dp
// Block table, search range registers, range check and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ucpl_dp
   import ucpl_pkg::*;
#(
   parameter int MAX_BLOCKS = 4096
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic                csr_we,
   input  wire logic [COUNT_W-1:0]  csr_data,
   input  wire logic [CODE_W-1:0]   req_code_point,
   input  wire logic [IDX_W-1:0]    req_entry_index,
   input  wire logic [CODE_W-1:0]   req_entry_start,
   input  wire logic [CODE_W-1:0]   req_entry_length,
   input  wire logic [CAT_W-1:0]    req_entry_category,
   input  wire logic [OFF_W-1:0]    req_entry_upper_offset,
   input  wire logic [OFF_W-1:0]    req_entry_lower_offset,
   input  wire logic [OFF_W-1:0]    req_entry_title_offset,
   output logic [CAT_W-1:0]         rsp_category,
   output logic [CODE_W-1:0]        rsp_upper_char,
   output logic [CODE_W-1:0]        rsp_lower_char,
   output logic [CODE_W-1:0]        rsp_title_char,
   output logic                     rsp_is_lower,
   output logic                     rsp_is_upper,
   output logic                     rsp_is_alnum,
   output logic                     rsp_is_print,
   output logic                     rsp_covered
);

   localparam int ADDR_W = $clog2(MAX_BLOCKS);

   entry_type mem [MAX_BLOCKS];
   entry_type rd_ff;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               empty_ff, empty_in;

   logic [CAT_W-1:0]   category_ff, category_in;
   logic [CODE_W-1:0]  upper_ff, upper_in, lower_ff, lower_in, title_ff, title_in;
   logic               is_lower_ff, is_lower_in, is_upper_ff, is_upper_in;
   logic               is_alnum_ff, is_alnum_in, is_print_ff, is_print_in;
   logic               covered_ff, covered_in;

   logic [31:0]        n_w, idx_w;
   logic [ADDR_W-1:0]  hi_init, wr_addr, probe_mid, rd_addr;
   logic [ADDR_W:0]    probe_sum, rd_sum;
   logic               start_le, in_block, hit, wr_ok;
   logic [CODE_W:0]    block_end;
   entry_type          wr_entry;

   // ---- configuration and search range ----
   always_comb begin
      count_in = csr_we ? csr_data : count_ff;
      n_w = 32'(count_ff);
      if (n_w > 32'(MAX_BLOCKS)) begin
         n_w = 32'(MAX_BLOCKS);
      end
      hi_init = (n_w == 32'd0) ? '0 : ADDR_W'(n_w - 32'd1);
   end

   assign probe_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + {{ADDR_W{1'b0}}, 1'b1};
   assign probe_mid = probe_sum[ADDR_W:1];
   assign start_le  = rd_ff.start <= code_ff;
   assign status.search_done = lo_ff == hi_ff;

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      code_in  = code_ff;
      empty_in = empty_ff;
      if (cmd.load) begin
         lo_in    = '0;
         hi_in    = hi_init;
         code_in  = req_code_point;
         empty_in = n_w == 32'd0;
      end else if (cmd.step) begin
         if (start_le) begin
            lo_in = probe_mid;
         end else begin
            hi_in = probe_mid - {{(ADDR_W-1){1'b0}}, 1'b1};
         end
      end
   end

   // next probe address; equals lo once the range has closed
   assign rd_sum  = {1'b0, lo_in} + {1'b0, hi_in} + {{ADDR_W{1'b0}}, 1'b1};
   assign rd_addr = rd_sum[ADDR_W:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      code_ff  <= code_in;
      empty_ff <= empty_in;
   end

   // ---- block table ----
   assign idx_w   = 32'(req_entry_index);
   assign wr_addr = idx_w[ADDR_W-1:0];
   assign wr_ok   = cmd.wr && idx_w < 32'(MAX_BLOCKS);

   always_comb begin
      wr_entry.start     = req_entry_start;
      wr_entry.length    = req_entry_length;
      wr_entry.category  = req_entry_category;
      wr_entry.upper_off = req_entry_upper_offset;
      wr_entry.lower_off = req_entry_lower_offset;
      wr_entry.title_off = req_entry_title_offset;
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_ff <= mem[rd_addr];
   end

   // ---- final range check and result ----
   assign block_end = {1'b0, rd_ff.start} + {1'b0, rd_ff.length};
   assign in_block  = {1'b0, code_ff} < block_end;
   assign hit       = start_le && in_block && !empty_ff;

   always_comb begin
      category_in = category_ff;
      upper_in    = upper_ff;
      lower_in    = lower_ff;
      title_in    = title_ff;
      covered_in  = covered_ff;
      if (cmd.finish) begin
         covered_in = hit;
         if (hit) begin
            category_in = rd_ff.category;
            upper_in    = map_char(code_ff, rd_ff.upper_off);
            lower_in    = map_char(code_ff, rd_ff.lower_off);
            title_in    = map_char(code_ff, rd_ff.title_off);
         end else begin
            category_in = CAT_CN;
            upper_in    = map_char(code_ff, '0);
            lower_in    = upper_in;
            title_in    = upper_in;
         end
      end
      is_lower_in = category_in == CAT_LL;
      is_upper_in = category_in == CAT_LU || category_in == CAT_LT ||
                    category_in == CAT_LM;
      is_alnum_in = category_in <= CAT_NO;
      is_print_in = category_in <= CAT_ZS;
   end

   always_ff @(posedge clock) begin
      category_ff <= category_in;
      upper_ff    <= upper_in;
      lower_ff    <= lower_in;
      title_ff    <= title_in;
      is_lower_ff <= is_lower_in;
      is_upper_ff <= is_upper_in;
      is_alnum_ff <= is_alnum_in;
      is_print_ff <= is_print_in;
      covered_ff  <= covered_in;
   end

   assign rsp_category   = category_ff;
   assign rsp_upper_char = upper_ff;
   assign rsp_lower_char = lower_ff;
   assign rsp_title_char = title_ff;
   assign rsp_is_lower   = is_lower_ff;
   assign rsp_is_upper   = is_upper_ff;
   assign rsp_is_alnum   = is_alnum_ff;
   assign rsp_is_print   = is_print_ff;
   assign rsp_covered    = covered_ff;

endmodule

`default_nettype wire

// ===== hdl/unicode_char_property_lookup.sv =====
// ----------------------------------------------------------------------------
// unicode_char_property_lookup
// General category and case mapping lookup over a sorted block table.
//
//   channel   handshake               beat carries
//   req       start & !busy           write entry or lookup code point
//   rsp       rsp_strobe (one cycle)  category, case maps, flags, covered
//   csr       csr_valid & csr_ready   block_count
//
// Write beats leave busy low, so the next beat can follow at once.
// A lookup is busy while it probes the table and during the final range check
// (n = block_count, capped at MAX_BLOCKS; for n of 0 or 1 only the range
// check runs). The next beat is taken at the end of the first cycle with busy
// low. The result strobes in that first cycle with busy low; no back-pressure.
// Reset is synchronous; table contents are not cleared and must be written.
// ----------------------------------------------------------------------------
`default_nettype none

module unicode_char_property_lookup
   import ucpl_pkg::*;
#(
   parameter int MAX_BLOCKS = 4096
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_action,
   input  wire logic [CODE_W-1:0]   req_code_point,
   input  wire logic [IDX_W-1:0]    req_entry_index,
   input  wire logic [CODE_W-1:0]   req_entry_start,
   input  wire logic [CODE_W-1:0]   req_entry_length,
   input  wire logic [CAT_W-1:0]    req_entry_category,
   input  wire logic [OFF_W-1:0]    req_entry_upper_offset,
   input  wire logic [OFF_W-1:0]    req_entry_lower_offset,
   input  wire logic [OFF_W-1:0]    req_entry_title_offset,
   output logic                     rsp_strobe,
   output logic [CAT_W-1:0]         rsp_category,
   output logic [CODE_W-1:0]        rsp_upper_char,
   output logic [CODE_W-1:0]        rsp_lower_char,
   output logic [CODE_W-1:0]        rsp_title_char,
   output logic                     rsp_is_lower,
   output logic                     rsp_is_upper,
   output logic                     rsp_is_alnum,
   output logic                     rsp_is_print,
   output logic                     rsp_covered,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [COUNT_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;
   logic       csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   ucpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ucpl_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_we                 (csr_we),
      .csr_data               (csr_data),
      .req_code_point         (req_code_point),
      .req_entry_index        (req_entry_index),
      .req_entry_start        (req_entry_start),
      .req_entry_length       (req_entry_length),
      .req_entry_category     (req_entry_category),
      .req_entry_upper_offset (req_entry_upper_offset),
      .req_entry_lower_offset (req_entry_lower_offset),
      .req_entry_title_offset (req_entry_title_offset),
      .rsp_category           (rsp_category),
      .rsp_upper_char         (rsp_upper_char),
      .rsp_lower_char         (rsp_lower_char),
      .rsp_title_char         (rsp_title_char),
      .rsp_is_lower           (rsp_is_lower),
      .rsp_is_upper           (rsp_is_upper),
      .rsp_is_alnum           (rsp_is_alnum),
      .rsp_is_print           (rsp_is_print),
      .rsp_covered            (rsp_covered)
   );

endmodule

`default_nettype wire

// ===== verif/char_property_checker.sv =====
// ----------------------------------------------------------------------------
// char_property_checker
// Watches the request, config and response channels of the character
// property lookup. Keeps its own block table and block count, works out the
// category, case maps and flags for every lookup beat, and compares each
// response strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module char_property_checker
   import ucpl_pkg::*;
#(
   parameter int MAX_BLOCKS = 4096
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_action,
   input  logic [CODE_W-1:0]  req_code_point,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic [CODE_W-1:0]  req_entry_start,
   input  logic [CODE_W-1:0]  req_entry_length,
   input  logic [CAT_W-1:0]   req_entry_category,
   input  logic [OFF_W-1:0]   req_entry_upper_offset,
   input  logic [OFF_W-1:0]   req_entry_lower_offset,
   input  logic [OFF_W-1:0]   req_entry_title_offset,
   input  logic               rsp_strobe,
   input  logic [CAT_W-1:0]   rsp_category,
   input  logic [CODE_W-1:0]  rsp_upper_char,
   input  logic [CODE_W-1:0]  rsp_lower_char,
   input  logic [CODE_W-1:0]  rsp_title_char,
   input  logic               rsp_is_lower,
   input  logic               rsp_is_upper,
   input  logic               rsp_is_alnum,
   input  logic               rsp_is_print,
   input  logic               rsp_covered,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data,
   output int                 errors,
   output int                 pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CAT_W-1:0]  category;
      logic [CODE_W-1:0] upper_char;
      logic [CODE_W-1:0] lower_char;
      logic [CODE_W-1:0] title_char;
      logic              is_lower;
      logic              is_upper;
      logic              is_alnum;
      logic              is_print;
      logic              covered;
   } char_props_type;

   entry_type          block_table [MAX_BLOCKS];
   logic [COUNT_W-1:0] active_blocks = COUNT_RESET;
   char_props_type     expected_props [$];
   char_props_type     want;
   int                 fail_count = 0;
   int                 in_flight = 0;

   assign errors  = fail_count;
   assign pending = in_flight;

   function automatic logic [CODE_W-1:0] offset_char(input logic [CODE_W-1:0] cp,
                                                     input logic [OFF_W-1:0] off);
      longint sum;
      sum = longint'(cp) + longint'($signed(off));
      if (sum < 0) begin
         return '0;
      end
      if (sum > longint'(MAX_CODE)) begin
         return MAX_CODE;
      end
      return sum[CODE_W-1:0];
   endfunction

   function automatic char_props_type lookup_props(input logic [CODE_W-1:0] cp);
      int unsigned      n;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      entry_type        hit_entry;
      logic [CAT_W-1:0] cat;
      logic [OFF_W-1:0] up_off;
      logic [OFF_W-1:0] low_off;
      logic [OFF_W-1:0] tit_off;
      char_props_type   res;
      n = (active_blocks > MAX_BLOCKS) ? MAX_BLOCKS : active_blocks;
      cat = CAT_CN;
      up_off = '0;
      low_off = '0;
      tit_off = '0;
      res.covered = 1'b0;
      if (n > 0) begin
         // last entry whose start is at or below the code point
         lo = 0;
         hi = n - 1;
         while (lo != hi) begin
            mid = (lo + hi + 1) / 2;
            if (block_table[mid].start <= cp) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         hit_entry = block_table[lo];
         if (hit_entry.start <= cp &&
             longint'(cp) < longint'(hit_entry.start) + longint'(hit_entry.length)) begin
            res.covered = 1'b1;
            cat = hit_entry.category;
            up_off = hit_entry.upper_off;
            low_off = hit_entry.lower_off;
            tit_off = hit_entry.title_off;
         end
      end
      res.category   = cat;
      res.upper_char = offset_char(cp, up_off);
      res.lower_char = offset_char(cp, low_off);
      res.title_char = offset_char(cp, tit_off);
      res.is_lower   = (cat == CAT_LL);
      res.is_upper   = (cat == CAT_LU) || (cat == CAT_LT) || (cat == CAT_LM);
      res.is_alnum   = (cat <= CAT_NO);
      res.is_print   = (cat <= CAT_ZS);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         fail_count = fail_count + 1;
         $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         active_blocks = COUNT_RESET;
         expected_props.delete();
      end else begin
         // responses first: a beat accepted at this edge cannot answer yet
         if (rsp_strobe) begin
            if (expected_props.size() == 0) begin
               fail_count = fail_count + 1;
               $display("%0t ns: response with no lookup outstanding: %s %0d",
                        $time, "expected none, actual category", rsp_category);
            end else begin
               want = expected_props.pop_front();
               check_field("category",   want.category,   rsp_category);
               check_field("upper_char", want.upper_char, rsp_upper_char);
               check_field("lower_char", want.lower_char, rsp_lower_char);
               check_field("title_char", want.title_char, rsp_title_char);
               check_field("is_lower",   want.is_lower,   rsp_is_lower);
               check_field("is_upper",   want.is_upper,   rsp_is_upper);
               check_field("is_alnum",   want.is_alnum,   rsp_is_alnum);
               check_field("is_print",   want.is_print,   rsp_is_print);
               check_field("covered",    want.covered,    rsp_covered);
            end
         end
         if (csr_valid && csr_ready) begin
            active_blocks = csr_data;
         end
         if (start && !busy) begin
            if (req_action == ACT_LOOKUP) begin
               expected_props.push_back(lookup_props(req_code_point));
            end else begin
               block_table[req_entry_index] = '{start:     req_entry_start,
                                                length:    req_entry_length,
                                                category:  req_entry_category,
                                                upper_off: req_entry_upper_offset,
                                                lower_off: req_entry_lower_offset,
                                                title_off: req_entry_title_offset};
            end
         end
      end
      in_flight <= expected_props.size();
   end

endmodule

// ===== verif/tb_unicode_char_property_lookup.sv =====
// ----------------------------------------------------------------------------
// tb_unicode_char_property_lookup
// Stimulus and verdict for the character property lookup. A directed
// section walks the corner cases (empty count, block misses, empty blocks,
// clamped maps, reserved categories, out-of-range code points), then random
// phases load sorted or scrambled block tables of varied size and fire
// lookups aimed at block edges and interiors. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_unicode_char_property_lookup;
   import ucpl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          TABLE_DEPTH = 4096;
   localparam int unsigned CODE_SPACE  = 1 << CODE_W;
   localparam int unsigned CODE_TOP    = CODE_SPACE - 1;
   localparam int          ITEM_GOAL   = 800;
   localparam int          SETTLE_CYC  = 20;

   // reserved category codes, stored and returned as is
   localparam logic [CAT_W-1:0] CAT_RSVD_A = 5'd30;
   localparam logic [CAT_W-1:0] CAT_RSVD_B = 5'd31;

   localparam logic [OFF_W-1:0] OFF_MAX_POS = 22'h1FFFFF;
   localparam logic [OFF_W-1:0] OFF_MAX_NEG = 22'h200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_action = ACT_WRITE;
   logic [CODE_W-1:0]  req_code_point = '0;
   logic [IDX_W-1:0]   req_entry_index = '0;
   logic [CODE_W-1:0]  req_entry_start = '0;
   logic [CODE_W-1:0]  req_entry_length = '0;
   logic [CAT_W-1:0]   req_entry_category = '0;
   logic [OFF_W-1:0]   req_entry_upper_offset = '0;
   logic [OFF_W-1:0]   req_entry_lower_offset = '0;
   logic [OFF_W-1:0]   req_entry_title_offset = '0;
   logic               rsp_strobe;
   logic [CAT_W-1:0]   rsp_category;
   logic [CODE_W-1:0]  rsp_upper_char;
   logic [CODE_W-1:0]  rsp_lower_char;
   logic [CODE_W-1:0]  rsp_title_char;
   logic               rsp_is_lower;
   logic               rsp_is_upper;
   logic               rsp_is_alnum;
   logic               rsp_is_print;
   logic               rsp_covered;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data = '0;
   int                 fail_count;
   int                 pending;

   int unsigned        wr_start [TABLE_DEPTH];
   int unsigned        wr_len [TABLE_DEPTH];
   int                 items_sent = 0;
   bit                 steady = 1'b0;

   unicode_char_property_lookup #(.MAX_BLOCKS(TABLE_DEPTH)) dut (.*);

   char_property_checker #(.MAX_BLOCKS(TABLE_DEPTH)) props_check (
      .clock, .reset, .start, .busy,
      .req_action, .req_code_point, .req_entry_index, .req_entry_start,
      .req_entry_length, .req_entry_category, .req_entry_upper_offset,
      .req_entry_lower_offset, .req_entry_title_offset,
      .rsp_strobe, .rsp_category, .rsp_upper_char, .rsp_lower_char,
      .rsp_title_char, .rsp_is_lower, .rsp_is_upper, .rsp_is_alnum,
      .rsp_is_print, .rsp_covered,
      .csr_valid, .csr_ready, .csr_data,
      .errors(fail_count), .pending(pending)
   );

   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic idle_gap();
      if (!steady && $urandom_range(0, 99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic load_block(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] st,
                             input logic [CODE_W-1:0] len, input logic [CAT_W-1:0] cat,
                             input logic [OFF_W-1:0] up_off, input logic [OFF_W-1:0] low_off,
                             input logic [OFF_W-1:0] tit_off);
      idle_gap();
      req_action             <= ACT_WRITE;
      req_entry_index        <= idx;
      req_entry_start        <= st;
      req_entry_length       <= len;
      req_entry_category     <= cat;
      req_entry_upper_offset <= up_off;
      req_entry_lower_offset <= low_off;
      req_entry_title_offset <= tit_off;
      start                  <= 1'b1;
      do @(posedge clock); while (busy);
      wr_start[idx] = st;
      wr_len[idx]   = len;
      items_sent++;
   endtask

   task automatic classify_char(input logic [CODE_W-1:0] cp);
      idle_gap();
      req_action     <= ACT_LOOKUP;
      req_code_point <= cp;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // wait out every outstanding lookup, then a little extra
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_block_count(input logic [COUNT_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [OFF_W-1:0] rand_offset();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return OFF_W'(int'($urandom_range(0, 128)) - 64);
         2: return OFF_W'($urandom);
         default: return $urandom_range(0, 1) ? OFF_MAX_POS : OFF_MAX_NEG;
      endcase
   endfunction

   // sorted: blocks laid out in ascending slices of the code space
   task automatic load_random_block(input int unsigned idx, input int unsigned n,
                                    input bit sorted);
      int unsigned seg;
      int unsigned st;
      int unsigned len;
      seg = CODE_SPACE / n;
      st = sorted ? idx * seg + $urandom_range(0, seg / 2) : $urandom_range(0, CODE_TOP);
      case ($urandom_range(0, 9))
         0: len = 0;
         1: len = $urandom_range(0, CODE_TOP);
         default: len = $urandom_range(1, seg);
      endcase
      if (len > CODE_TOP) len = CODE_TOP;
      load_block(IDX_W'(idx), CODE_W'(st), CODE_W'(len), CAT_W'($urandom_range(0, 31)),
                 rand_offset(), rand_offset(), rand_offset());
   endtask

   // code point aimed at a loaded block: inside, just below, just past, anywhere, or at or above MAX_CODE
   function automatic logic [CODE_W-1:0] pick_code(input int unsigned n);
      int unsigned j;
      int unsigned cp;
      j = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5:
            cp = wr_start[j] + ((wr_len[j] == 0) ? 0 : $urandom_range(0, wr_len[j] - 1));
         6: cp = wr_start[j] - 1;
         7: cp = wr_start[j] + wr_len[j];
         8: cp = $urandom_range(0, CODE_TOP);
         default: cp = $urandom_range(MAX_CODE, CODE_TOP);
      endcase
      return CODE_W'(cp);
   endfunction

   initial begin
      int unsigned count;
      int unsigned eff;
      int unsigned n_look;
      int unsigned budget;
      int          phase;
      bit          sorted;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset count is one: single block A..Z
      load_block(0, 21'h41, 21'd26, CAT_LU, 0, 22'd32, 0);
      classify_char(21'h40);
      classify_char(21'h41);
      classify_char(21'h5A);
      classify_char(21'h5B);

      // no valid entries
      drain();
      set_block_count('0);
      classify_char(21'h41);
      classify_char(MAX_CODE);

      drain();
      set_block_count(13'd4);
      load_block(0, 21'h0,   21'h41, CAT_ZS, 0, 0, 0);
      load_block(1, 21'h41,  21'd26, CAT_LU, 0, 22'd32, 0);
      load_block(2, 21'h61,  21'd26, CAT_LL, -22'sd32, 0, -22'sd32);
      load_block(3, 21'h100, 21'd0,  CAT_LT, 0, 0, 0);   // empty block
      classify_char(21'h0);
      classify_char(21'h41);
      classify_char(21'h5A);
      classify_char(21'h61);
      classify_char(21'h7A);
      classify_char(21'h100);
      classify_char(MAX_CODE);
      // huge block, reserved category, maps that clamp both ways
      load_block(3, 21'h100000, CODE_W'(CODE_TOP), CAT_RSVD_B, OFF_MAX_POS, OFF_MAX_NEG, 0);
      classify_char(MAX_CODE);
      classify_char(CODE_W'(CODE_TOP));
      classify_char(21'h100000);

      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         case (phase)
            0: count = 256;
            1: count = 1;
            default: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: count = $urandom_range(1, 16);
                  6, 7: count = $urandom_range(17, 100);
                  8: count = $urandom_range(101, 200);
                  default: count = 0;
               endcase
            end
         endcase
         // keep the table load within what is left of the beat budget
         budget = ITEM_GOAL - items_sent;
         if (count + 10 > budget) begin
            count = (budget > 11) ? budget - 10 : 1;
         end
         eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
         drain();
         steady = (phase == 0) || (phase == 6);
         set_block_count(COUNT_W'(count));
         sorted = (phase < 3) || ($urandom_range(0, 4) != 0);
         for (int unsigned i = 0; i < eff; i++) begin
            load_random_block(i, eff, sorted);
         end
         n_look = $urandom_range(10, 40);
         for (int unsigned k = 0; k < n_look && items_sent < ITEM_GOAL; k++) begin
            if (eff > 0 && $urandom_range(0, 19) == 0) begin
               load_random_block($urandom_range(0, eff - 1), eff, sorted);
            end
            classify_char((eff > 0) ? pick_code(eff) : CODE_W'($urandom_range(0, CODE_TOP)));
         end
         phase++;
      end

      steady = 1'b0;
      drain();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ucpl_pkg.sv
hdl/ucpl_ctrl.sv
hdl/ucpl_dp.sv
hdl/unicode_char_property_lookup.sv
verif/char_property_checker.sv
verif/tb_unicode_char_property_lookup.sv
